// ===== sv/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Widths, byte classes, range limits and the result record used by the
// UTF-8 validating decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int CP_W    = 21;
    localparam int USED_W  = 3;
    localparam int BITS_W  = 18;
    localparam int CNT_W   = 2;
    localparam int MAX_RES = 4;
    localparam int RES_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // byte classes
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD_MAX    = 8'hF4;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    // value limits
    localparam logic [CP_W-1:0] MIN_3B    = 21'h000800;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_4B    = 21'h010000;
    localparam logic [CP_W-1:0] MAX_SCALR = 21'h10FFFF;

    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic              repl;
        logic [USED_W-1:0] used;
    } res_t;

    localparam res_t REPL_RES = '{cp: REPL_CP, repl: 1'b1, used: 3'd1};

endpackage

// ===== sv/utf8_validating_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_validating_decoder
// A request is held in the input register and decoded into the batch register,
// which drives the outputs directly.
// Throughput: one byte per cycle while each byte gives at most one result and
// out_stall is low; N results of one byte (N up to 4) go out one per cycle.
// Reset (rst_n low, asynchronous) empties all stages and closes any sequence.
// ----------------------------------------------------------------------------
module utf8_validating_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  in_byte,
    input  logic                        end_of_text,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u8d_pkg::CP_W-1:0]    code_point,
    output logic                        is_replacement,
    output logic [u8d_pkg::USED_W-1:0]  bytes_used,
    output logic                        last_of_run
);
    import u8d_pkg::*;

    // ------------------------------------------------------------------
    // Input register: holds one request until the decode stage takes it.
    // ------------------------------------------------------------------
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       eot_reg;

    // Decoder state: open lead and the continuations gathered so far.
    logic [7:0]        lead_reg,  lead_next;
    logic [BITS_W-1:0] gbits_reg, gbits_next;
    logic [CNT_W-1:0]  gcnt_reg,  gcnt_next;
    logic [CNT_W-1:0]  need_reg,  need_next;

    // Result batch: every result of one request, sent one per cycle while out_stall is low.
    res_t             batch_reg [MAX_RES];
    logic [RES_W-1:0] batch_cnt_reg;
    logic [IDX_W-1:0] batch_idx_reg;
    logic             batch_valid_reg;

    // Decode outputs
    res_t             res [MAX_RES];
    logic [RES_W-1:0] n_res;

    logic in_fire, out_fire, batch_last, batch_free, move;

    // ------------------------------------------------------------------
    // Decode. All replacements carry the same record, so the list starts
    // filled with them and only a decoded value is written in; flushing
    // then just advances the count. The longest list is a flush of a lead
    // and two continuations, then either the breaking byte's own result or an
    // end-of-text flush of the lead it freshly opens: four entries.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic              is_cont;
        logic              open_fresh;
        logic [BITS_W-1:0] nbits;
        logic [CNT_W-1:0]  ncnt;
        logic [CP_W-1:0]   v;
        logic              ok;

        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = REPL_RES;
        end
        n_res      = '0;
        lead_next  = lead_reg;
        gbits_next = gbits_reg;
        gcnt_next  = gcnt_reg;
        need_next  = need_reg;

        is_cont    = (byte_reg & CONT_MASK) == CONT_TAG;
        open_fresh = 1'b0;
        nbits      = {gbits_reg[BITS_W-7:0], byte_reg[5:0]};
        ncnt       = gcnt_reg + 2'd1;
        v          = '0;
        ok         = 1'b0;

        if (need_reg != '0 && is_cont)
        begin
            gbits_next = nbits;
            gcnt_next  = ncnt;
            if (ncnt == need_reg)
            begin
                case (need_reg)
                    2'd1:
                    begin
                        v  = {10'd0, lead_reg[4:0], nbits[5:0]};
                        ok = 1'b1;
                    end
                    2'd2:
                    begin
                        v  = {5'd0, lead_reg[3:0], nbits[11:0]};
                        ok = (v >= MIN_3B) && !((v >= SURR_LO) && (v <= SURR_HI));
                    end
                    default:
                    begin
                        v  = {lead_reg[2:0], nbits[17:0]};
                        ok = (v >= MIN_4B) && (v <= MAX_SCALR);
                    end
                endcase
                if (ok)
                begin
                    res[0] = '{cp: v, repl: 1'b0, used: {1'b0, need_reg} + 3'd1};
                    n_res  = 3'd1;
                end
                else
                begin
                    // lead plus each of its continuations
                    n_res = 3'd1 + {1'b0, ncnt};
                end
                lead_next  = '0;
                gbits_next = '0;
                gcnt_next  = '0;
                need_next  = '0;
            end
        end
        else
        begin
            // a byte that breaks an open sequence drops it first
            if (need_reg != '0)
            begin
                n_res = 3'd1 + {1'b0, gcnt_reg};
            end
            lead_next  = '0;
            gbits_next = '0;
            gcnt_next  = '0;
            need_next  = '0;
            // then the byte decodes afresh
            if (byte_reg < ASCII_LIMIT)
            begin
                res[n_res[IDX_W-1:0]] = '{cp: {13'd0, byte_reg}, repl: 1'b0, used: 3'd1};
                n_res = n_res + 3'd1;
            end
            else if (byte_reg < LEAD2_MIN || byte_reg > LEAD_MAX)
            begin
                n_res = n_res + 3'd1;
            end
            else
            begin
                open_fresh = 1'b1;
                lead_next  = byte_reg;
                if (byte_reg < LEAD3_MIN)
                    need_next = 2'd1;
                else if (byte_reg < LEAD4_MIN)
                    need_next = 2'd2;
                else
                    need_next = 2'd3;
            end
        end

        // end of text flushes whatever stays open
        if (eot_reg && need_next != '0)
        begin
            n_res = n_res + 3'd1 + (open_fresh ? 3'd0 : {1'b0, gcnt_next});
            lead_next  = '0;
            gbits_next = '0;
            gcnt_next  = '0;
            need_next  = '0;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A request that gives no result only moves the state, so
    // it passes even while the batch is busy.
    // ------------------------------------------------------------------
    assign out_valid  = batch_valid_reg;
    assign out_fire   = batch_valid_reg && !out_stall;
    assign batch_last = {1'b0, batch_idx_reg} == (batch_cnt_reg - 3'd1);
    assign batch_free = !batch_valid_reg || (out_fire && batch_last);
    assign move       = in_valid_reg && (n_res == '0 || batch_free);
    assign in_stall   = in_valid_reg && !move;
    assign in_fire    = in_valid && !in_stall;

    assign in_valid_next = in_fire || (in_valid_reg && !move);

    // Output comes straight from the batch register; the index moves only
    // on a taken result, so a stalled result holds.
    assign code_point     = batch_reg[batch_idx_reg].cp;
    assign is_replacement = batch_reg[batch_idx_reg].repl;
    assign bytes_used     = batch_reg[batch_idx_reg].used;
    assign last_of_run    = batch_last;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            lead_reg        <= '0;
            gbits_reg       <= '0;
            gcnt_reg        <= '0;
            need_reg        <= '0;
            batch_valid_reg <= 1'b0;
            batch_cnt_reg   <= '0;
            batch_idx_reg   <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (move)
            begin
                lead_reg  <= lead_next;
                gbits_reg <= gbits_next;
                gcnt_reg  <= gcnt_next;
                need_reg  <= need_next;
            end
            if (move && n_res != '0)
            begin
                batch_valid_reg <= 1'b1;
                batch_cnt_reg   <= n_res;
                batch_idx_reg   <= '0;
            end
            else if (out_fire)
            begin
                if (batch_last)
                    batch_valid_reg <= 1'b0;
                else
                    batch_idx_reg <= batch_idx_reg + 2'd1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= in_byte;
            eot_reg  <= end_of_text;
        end
        if (move && n_res != '0)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                batch_reg[i] <= res[i];
            end
        end
    end

endmodule
